// ===== rtl/psp_pkg.sv =====
// Package for the pie sector pixel classifier: shared types, widths and constants.
// Used by every module of the block; depends on nothing.
package psp_pkg;

  // Field widths
  localparam int OFS_W   = 8;
  localparam int CRD_W   = 10;
  localparam int PIX_W   = 11;
  localparam int RAD_W   = 8;
  localparam int SLOPE_W = 18;

  // Divider: dividend is offset_y * 100, at most 25500, held in 15 bits
  localparam int NUM_W      = 15;
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = NUM_W / DIV_STEPS;
  localparam int QUO_MAX    = 25500;

  localparam logic [NUM_W-1:0] SLOPE_SCALE = NUM_W'(100);
  // Slope of a vertical offset (offset_x of zero)
  localparam logic signed [SLOPE_W-1:0] SLOPE_VERT = 18'sd99000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CENTRE_X    = 3'd0,
    REG_CENTRE_Y    = 3'd1,
    REG_RADIUS      = 3'd2,
    REG_RIGHT_LOW   = 3'd3,
    REG_RIGHT_HIGH  = 3'd4,
    REG_LEFT_LOW    = 3'd5,
    REG_LEFT_HIGH   = 3'd6,
    REG_ENABLE      = 3'd7
  } psp_reg_t;

  // Configuration as seen by the pipeline
  typedef struct packed {
    logic [CRD_W-1:0]          centre_x;
    logic [CRD_W-1:0]          centre_y;
    logic [RAD_W-1:0]          circle_radius;   // already clipped to the maximum radius
    logic signed [SLOPE_W-1:0] right_low_bound;
    logic signed [SLOPE_W-1:0] right_high_bound;
    logic signed [SLOPE_W-1:0] left_low_bound;
    logic signed [SLOPE_W-1:0] left_high_bound;
    logic                      sector_enable;
  } psp_cfg_t;

  // Side information that travels with each beat down the pipe
  typedef struct packed {
    logic                    vld;
    logic                    dx_zero;
    logic                    in_disc;
    logic [PIX_W-1:0]        column_right;
    logic signed [PIX_W-1:0] column_left;
    logic signed [PIX_W-1:0] row_upper;
    logic [PIX_W-1:0]        row_lower;
  } psp_tag_t;

  // Long division state between divider stages
  typedef struct packed {
    logic [OFS_W-1:0] rem;
    logic [OFS_W-1:0] dvs;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
  } psp_div_t;

  // Half-open slope window test: low <= s < high
  function automatic logic in_window(input logic signed [SLOPE_W-1:0] s,
                                     input logic signed [SLOPE_W-1:0] lo,
                                     input logic signed [SLOPE_W-1:0] hi);
    return (s >= lo) && (s < hi);
  endfunction

endpackage

// ===== rtl/psp_front.sv =====
// Front end of the classifier: two register stages for squares, disc test,
// slope dividend and screen coordinates. Depends on psp_pkg.
module psp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_fire,
  input  logic [psp_pkg::OFS_W-1:0] offset_x,
  input  logic [psp_pkg::OFS_W-1:0] offset_y,
  input  psp_pkg::psp_cfg_t         cfg,
  output psp_pkg::psp_tag_t         tag,
  output psp_pkg::psp_div_t         div
);
  import psp_pkg::*;

  // Stage one registers
  psp_tag_t                 tag1;
  logic [OFS_W-1:0]         ox1;
  logic [NUM_W-1:0]         num1;
  logic [2*OFS_W-1:0]       sqx1;
  logic [2*OFS_W-1:0]       sqy1;
  logic [2*RAD_W-1:0]       sqr1;

  psp_tag_t                 tag1_next;
  logic [2*OFS_W:0]         dist_sum;

  // Coordinates and flags for the incoming beat
  always_comb begin
    tag1_next.vld          = in_fire;
    tag1_next.dx_zero      = (offset_x == '0);
    tag1_next.in_disc      = 1'b0;
    tag1_next.column_right = PIX_W'(cfg.centre_x) + PIX_W'(offset_x);
    tag1_next.column_left  = $signed(PIX_W'(cfg.centre_x) - PIX_W'(offset_x));
    tag1_next.row_upper    = $signed(PIX_W'(cfg.centre_y) - PIX_W'(offset_y));
    tag1_next.row_lower    = PIX_W'(cfg.centre_y) + PIX_W'(offset_y);
  end

  // Stage one: squares and dividend
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.vld <= 1'b0;
    end else if (adv) begin
      tag1.vld <= tag1_next.vld;
    end
    if (adv) begin
      tag1.dx_zero      <= tag1_next.dx_zero;
      tag1.in_disc      <= tag1_next.in_disc;
      tag1.column_right <= tag1_next.column_right;
      tag1.column_left  <= tag1_next.column_left;
      tag1.row_upper    <= tag1_next.row_upper;
      tag1.row_lower    <= tag1_next.row_lower;
      ox1  <= offset_x;
      num1 <= NUM_W'(offset_y) * SLOPE_SCALE;
      sqx1 <= (2*OFS_W)'(offset_x) * (2*OFS_W)'(offset_x);
      sqy1 <= (2*OFS_W)'(offset_y) * (2*OFS_W)'(offset_y);
      sqr1 <= (2*RAD_W)'(cfg.circle_radius) * (2*RAD_W)'(cfg.circle_radius);
    end
  end

  // Stage two: disc test
  assign dist_sum = (2*OFS_W+1)'(sqx1) + (2*OFS_W+1)'(sqy1);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.vld <= 1'b0;
    end else if (adv) begin
      tag.vld <= tag1.vld;
    end
    if (adv) begin
      tag.dx_zero      <= tag1.dx_zero;
      tag.in_disc      <= (dist_sum <= (2*OFS_W+1)'(sqr1));
      tag.column_right <= tag1.column_right;
      tag.column_left  <= tag1.column_left;
      tag.row_upper    <= tag1.row_upper;
      tag.row_lower    <= tag1.row_lower;
      div.rem <= '0;
      div.dvs <= ox1;
      div.num <= num1;
      div.quo <= '0;
    end
  end

endmodule

// ===== rtl/psp_div_stage.sv =====
// One stage of the pipelined restoring divider: resolves DIV_STEPS quotient
// bits per cycle while adv lets the pipe move, and forwards the side tag. Depends on psp_pkg.
module psp_div_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  psp_pkg::psp_tag_t tag_in,
  input  psp_pkg::psp_div_t div_in,
  output psp_pkg::psp_tag_t tag_out,
  output psp_pkg::psp_div_t div_out
);
  import psp_pkg::*;

  psp_div_t div_next;

  // Shift-subtract steps, most significant dividend bit first
  always_comb begin
    logic [OFS_W-1:0]     rem;
    logic [OFS_W:0]       trial;
    logic [DIV_STEPS-1:0] qbits;
    rem   = div_in.rem;
    qbits = '0;
    for (int j = 0; j < DIV_STEPS; j++) begin
      trial = {rem, div_in.num[NUM_W-1-j]};
      if (trial >= {1'b0, div_in.dvs}) begin
        rem                    = OFS_W'(trial - {1'b0, div_in.dvs});
        qbits[DIV_STEPS-1-j]   = 1'b1;
      end else begin
        rem = trial[OFS_W-1:0];
      end
    end
    div_next.rem = rem;
    div_next.dvs = div_in.dvs;
    div_next.num = div_in.num << DIV_STEPS;
    div_next.quo = {div_in.quo[NUM_W-1-DIV_STEPS:0], qbits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.vld <= 1'b0;
    end else if (adv) begin
      tag_out.vld <= tag_in.vld;
    end
    if (adv) begin
      tag_out.dx_zero      <= tag_in.dx_zero;
      tag_out.in_disc      <= tag_in.in_disc;
      tag_out.column_right <= tag_in.column_right;
      tag_out.column_left  <= tag_in.column_left;
      tag_out.row_upper    <= tag_in.row_upper;
      tag_out.row_lower    <= tag_in.row_lower;
      div_out              <= div_next;
    end
  end

`ifndef ASSERT_OFF
  // Partial remainder always stays below a nonzero divisor
  a_rem_below_dvs: assert property (@(posedge clk) disable iff (rst)
    (tag_out.vld && !tag_out.dx_zero) |-> (div_out.rem < div_out.dvs))
    else $error("divider remainder not below divisor");
`endif

endmodule

// ===== rtl/psp_classify.sv =====
// Final stage: slope selection, four window tests and the output register.
// Depends on psp_pkg.
module psp_classify (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  psp_pkg::psp_tag_t                tag,
  input  logic [psp_pkg::NUM_W-1:0]        quo,
  input  psp_pkg::psp_cfg_t                cfg,
  output logic                             out_valid,
  output logic                             hit_upper_right,
  output logic                             hit_lower_right,
  output logic                             hit_upper_left,
  output logic                             hit_lower_left,
  output logic [psp_pkg::PIX_W-1:0]        column_right,
  output logic signed [psp_pkg::PIX_W-1:0] column_left,
  output logic signed [psp_pkg::PIX_W-1:0] row_upper,
  output logic [psp_pkg::PIX_W-1:0]        row_lower
);
  import psp_pkg::*;

  logic signed [SLOPE_W-1:0] slope;
  logic signed [SLOPE_W-1:0] slope_neg;
  logic                      go;

  // Slope and its mirror, vertical offsets use the sentinel
  assign slope     = tag.dx_zero ? SLOPE_VERT : $signed(SLOPE_W'(quo));
  assign slope_neg = -slope;
  assign go        = tag.in_disc && cfg.sector_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tag.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_upper_right <= go && in_window(slope, cfg.right_low_bound, cfg.right_high_bound);
      hit_lower_right <= go && in_window(slope_neg, cfg.right_low_bound, cfg.right_high_bound);
      hit_upper_left  <= go && in_window(slope, cfg.left_low_bound, cfg.left_high_bound);
      hit_lower_left  <= go && in_window(slope_neg, cfg.left_low_bound, cfg.left_high_bound);
      column_right    <= tag.column_right;
      column_left     <= tag.column_left;
      row_upper       <= tag.row_upper;
      row_lower       <= tag.row_lower;
    end
  end

`ifndef ASSERT_OFF
  // Quotient of a dividend of at most 25500 by a nonzero divisor
  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    (tag.vld && !tag.dx_zero) |-> (quo <= NUM_W'(QUO_MAX)))
    else $error("slope quotient out of range");
`endif

endmodule

// ===== rtl/pie_sector_pixel_classifier_core.sv =====
// Top level of the pie sector pixel classifier: configuration registers and
// the pipeline of psp_front, psp_div_stage and psp_classify. Depends on psp_pkg.
//
// Usage:
// - Input channel in_valid/in_ready carries one grid offset (offset_x, offset_y)
//   per beat; output channel out_valid/out_ready carries the four hit flags and
//   the four screen coordinates of the mirrored pixels.
// - Configuration: cfg_we writes cfg_data into register cfg_index
//   (centre, radius, four slope bounds, enable). Write only while the pipe is
//   empty. A radius above RADIUS_MAX is stored as RADIUS_MAX.
// - Throughput: one beat per cycle while the pipe is not stalled. Each beat
//   passes through two front stages (squares, disc test), five divider
//   stages of three quotient bits each, and the output register.
// - Stall: when out_valid is high and out_ready low, the whole pipe holds;
//   in_ready drops and nothing is lost or repeated. A bubble at the output
//   register is filled even while the receiver is stalled.
// - Reset (rst, synchronous): clears all stage valid bits and all
//   configuration registers to zero.
module pie_sector_pixel_classifier_core #(
  parameter int RADIUS_MAX = 255
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_index,
  input  logic [psp_pkg::SLOPE_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [psp_pkg::OFS_W-1:0]        offset_x,
  input  logic [psp_pkg::OFS_W-1:0]        offset_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             hit_upper_right,
  output logic                             hit_lower_right,
  output logic                             hit_upper_left,
  output logic                             hit_lower_left,
  output logic [psp_pkg::PIX_W-1:0]        column_right,
  output logic signed [psp_pkg::PIX_W-1:0] column_left,
  output logic signed [psp_pkg::PIX_W-1:0] row_upper,
  output logic [psp_pkg::PIX_W-1:0]        row_lower
);
  import psp_pkg::*;

  localparam int RMAX_W = $clog2(RADIUS_MAX + 1);
  localparam int CMP_W  = (RMAX_W > RAD_W) ? RMAX_W : RAD_W;
  localparam logic [CMP_W-1:0] RMAX_C = CMP_W'(RADIUS_MAX);

  psp_cfg_t         cfg;
  logic             adv;
  logic [CMP_W-1:0] radius_wr;
  psp_tag_t         tag [DIV_STAGES+1];
  psp_div_t         div [DIV_STAGES+1];
  logic [DIV_STAGES:0] stage_vld;

  // Global stall: the pipe moves when the output register is free or taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Configuration registers
  assign radius_wr = CMP_W'(cfg_data[RAD_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (psp_reg_t'(cfg_index))
        REG_CENTRE_X:   cfg.centre_x <= cfg_data[CRD_W-1:0];
        REG_CENTRE_Y:   cfg.centre_y <= cfg_data[CRD_W-1:0];
        REG_RADIUS:     cfg.circle_radius <= (radius_wr > RMAX_C) ?
                                             RMAX_C[RAD_W-1:0] : cfg_data[RAD_W-1:0];
        REG_RIGHT_LOW:  cfg.right_low_bound <= $signed(cfg_data);
        REG_RIGHT_HIGH: cfg.right_high_bound <= $signed(cfg_data);
        REG_LEFT_LOW:   cfg.left_low_bound <= $signed(cfg_data);
        REG_LEFT_HIGH:  cfg.left_high_bound <= $signed(cfg_data);
        REG_ENABLE:     cfg.sector_enable <= cfg_data[0];
      endcase
    end
  end

  // Front end
  psp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_fire  (in_valid && in_ready),
    .offset_x (offset_x),
    .offset_y (offset_y),
    .cfg      (cfg),
    .tag      (tag[0]),
    .div      (div[0])
  );

  // Divider chain
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    psp_div_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tag_in  (tag[k]),
      .div_in  (div[k]),
      .tag_out (tag[k+1]),
      .div_out (div[k+1])
    );
  end

  for (genvar k = 0; k <= DIV_STAGES; k++) begin : g_vld
    assign stage_vld[k] = tag[k].vld;
  end

  // Window tests and output register
  psp_classify u_classify (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .tag             (tag[DIV_STAGES]),
    .quo             (div[DIV_STAGES].quo),
    .cfg             (cfg),
    .out_valid       (out_valid),
    .hit_upper_right (hit_upper_right),
    .hit_lower_right (hit_lower_right),
    .hit_upper_left  (hit_upper_left),
    .hit_lower_left  (hit_lower_left),
    .column_right    (column_right),
    .column_left     (column_left),
    .row_upper       (row_upper),
    .row_lower       (row_lower)
  );

`ifndef ASSERT_OFF
  // A stalled pipe keeps every stage's valid bit
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(stage_vld) && out_valid)
    else $error("pipeline moved during stall");

  // Reset empties the output stage and clears every stage valid bit
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && (stage_vld == '0))
    else $error("pipeline not empty after reset");

  // A beat leaving the last divider stage lands in the output register
  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    (adv && stage_vld[DIV_STAGES]) |=> out_valid)
    else $error("beat lost at output register");
`endif

endmodule

// ===== tb/sv/psp_sector_checker.sv =====
`timescale 1ns / 1ps
// Sector pixel checker: tracks configuration writes, predicts the hit flags and
// coordinates of each accepted offset beat, and compares every result beat in order.
// Depends on psp_pkg.
module psp_sector_checker #(
  parameter int RADIUS_MAX = 255
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [2:0]                         cfg_index,
  input  logic [psp_pkg::SLOPE_W-1:0]        cfg_data,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [psp_pkg::OFS_W-1:0]          offset_x,
  input  logic [psp_pkg::OFS_W-1:0]          offset_y,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic                               hit_upper_right,
  input  logic                               hit_lower_right,
  input  logic                               hit_upper_left,
  input  logic                               hit_lower_left,
  input  logic [psp_pkg::PIX_W-1:0]          column_right,
  input  logic signed [psp_pkg::PIX_W-1:0]   column_left,
  input  logic signed [psp_pkg::PIX_W-1:0]   row_upper,
  input  logic [psp_pkg::PIX_W-1:0]          row_lower,
  output int                                 errors,
  output int                                 pending,
  output int                                 beats_checked
);
  import psp_pkg::*;

  typedef struct {
    bit                      hit_ur;
    bit                      hit_lr;
    bit                      hit_ul;
    bit                      hit_ll;
    logic [PIX_W-1:0]        col_r;
    logic signed [PIX_W-1:0] col_l;
    logic signed [PIX_W-1:0] row_u;
    logic [PIX_W-1:0]        row_l;
  } pixel_set_t;

  // Predicted results, oldest first
  pixel_set_t expected_pixels[$];

  // Shadow copy of the sector setup
  int cx, cy, radius, enable;
  int right_lo, right_hi, left_lo, left_hi;

  function automatic bit in_sector(int s, int lo, int hi);
    return (s >= lo) && (s < hi);
  endfunction

  // Disc test, slope, four mirrored window tests and the pixel coordinates
  function automatic pixel_set_t classify_offset(logic [OFS_W-1:0] ox,
                                                 logic [OFS_W-1:0] oy);
    pixel_set_t p;
    int dx, dy, r, slope;
    bit go;
    dx = ox;
    dy = oy;
    r = (radius > RADIUS_MAX) ? RADIUS_MAX : radius;
    go = (enable != 0) && (dx * dx + dy * dy <= r * r);
    // vertical offset gets the steep sentinel slope
    slope = (dx == 0) ? int'(SLOPE_VERT) : (dy * int'(SLOPE_SCALE)) / dx;
    p.hit_ur = go && in_sector(slope, right_lo, right_hi);
    p.hit_lr = go && in_sector(-slope, right_lo, right_hi);
    p.hit_ul = go && in_sector(slope, left_lo, left_hi);
    p.hit_ll = go && in_sector(-slope, left_lo, left_hi);
    p.col_r = PIX_W'(cx + dx);
    p.col_l = PIX_W'(cx - dx);
    p.row_u = PIX_W'(cy - dy);
    p.row_l = PIX_W'(cy + dy);
    return p;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Monitor: config writes, offset beats in, result beats out
  always @(posedge clk) begin
    pixel_set_t want;
    if (rst) begin
      cx = 0;
      cy = 0;
      radius = 0;
      enable = 0;
      right_lo = 0;
      right_hi = 0;
      left_lo = 0;
      left_hi = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (psp_reg_t'(cfg_index))
          REG_CENTRE_X:   cx = int'(cfg_data[CRD_W-1:0]);
          REG_CENTRE_Y:   cy = int'(cfg_data[CRD_W-1:0]);
          REG_RADIUS:     radius = int'(cfg_data[RAD_W-1:0]);
          REG_RIGHT_LOW:  right_lo = int'($signed(cfg_data));
          REG_RIGHT_HIGH: right_hi = int'($signed(cfg_data));
          REG_LEFT_LOW:   left_lo = int'($signed(cfg_data));
          REG_LEFT_HIGH:  left_hi = int'($signed(cfg_data));
          REG_ENABLE:     enable = int'(cfg_data[0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_pixels.push_back(classify_offset(offset_x, offset_y));
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result beat arrived with no offset outstanding");
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("hit_upper_right", want.hit_ur, hit_upper_right);
          check_field("hit_lower_right", want.hit_lr, hit_lower_right);
          check_field("hit_upper_left", want.hit_ul, hit_upper_left);
          check_field("hit_lower_left", want.hit_ll, hit_lower_left);
          check_field("column_right", want.col_r, column_right);
          check_field("column_left", want.col_l, column_left);
          check_field("row_upper", want.row_u, row_upper);
          check_field("row_lower", want.row_l, row_lower);
          beats_checked++;
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the sector classifier bench: clock, reset, offset and config stimulus,
// receiver stalls, watchdog and verdict. Depends on psp_pkg, psp_sector_checker and pie_sector_pixel_classifier_core.
module tb_top;
  import psp_pkg::*;

  localparam int RADIUS_LIMIT    = 255;
  localparam int LATENCY         = 8;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 100;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [2:0]              cfg_index = '0;
  logic [SLOPE_W-1:0]      cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OFS_W-1:0]        offset_x = '0;
  logic [OFS_W-1:0]        offset_y = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    hit_upper_right, hit_lower_right;
  logic                    hit_upper_left, hit_lower_left;
  logic [PIX_W-1:0]        column_right, row_lower;
  logic signed [PIX_W-1:0] column_left, row_upper;

  int errors, pending, beats_checked;
  int send_idle_pct = 25;
  int recv_idle_pct = 63;
  int radius_now = 0;
  int idle_cycles = 0;
  int settings_run = 0;
  int offsets_sent = 0;

  pie_sector_pixel_classifier_core #(.RADIUS_MAX(RADIUS_LIMIT)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .offset_x(offset_x), .offset_y(offset_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit_upper_right(hit_upper_right), .hit_lower_right(hit_lower_right),
    .hit_upper_left(hit_upper_left), .hit_lower_left(hit_lower_left),
    .column_right(column_right), .column_left(column_left),
    .row_upper(row_upper), .row_lower(row_lower)
  );

  psp_sector_checker #(.RADIUS_MAX(RADIUS_LIMIT)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .offset_x(offset_x), .offset_y(offset_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit_upper_right(hit_upper_right), .hit_lower_right(hit_lower_right),
    .hit_upper_left(hit_upper_left), .hit_lower_left(hit_lower_left),
    .column_right(column_right), .column_left(column_left),
    .row_upper(row_upper), .row_lower(row_lower),
    .errors(errors), .pending(pending), .beats_checked(beats_checked)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: too long without any beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // One register write; called and returns at a falling edge
  task automatic write_reg(psp_reg_t idx, logic [SLOPE_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    if (idx == REG_RADIUS)
      radius_now = int'(value[RAD_W-1:0]);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_sector(int cx, int cy, int rad, int rl, int rh, int ll, int lh,
                            int en);
    write_reg(REG_CENTRE_X, SLOPE_W'(cx));
    write_reg(REG_CENTRE_Y, SLOPE_W'(cy));
    write_reg(REG_RADIUS, SLOPE_W'(rad));
    write_reg(REG_RIGHT_LOW, SLOPE_W'(rl));
    write_reg(REG_RIGHT_HIGH, SLOPE_W'(rh));
    write_reg(REG_LEFT_LOW, SLOPE_W'(ll));
    write_reg(REG_LEFT_HIGH, SLOPE_W'(lh));
    write_reg(REG_ENABLE, SLOPE_W'(en));
    settings_run++;
  endtask

  // Hold off until the pipe is empty, then let it settle
  task automatic drain_pipe();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  // Drive one offset beat with a random lead-in gap
  task automatic send_offset(int ox, int oy);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    offset_x = OFS_W'(ox);
    offset_y = OFS_W'(oy);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    offsets_sent++;
  endtask

  // Slope bound: sentinels, in-range values, exact point slopes, raw 18-bit data
  function automatic int pick_bound();
    int v, dx;
    case ($urandom_range(0, 5))
      0: v = 100000;
      1: v = -100000;
      2: v = int'($urandom_range(0, 200000)) - 100000;
      3: begin
        dx = $urandom_range(1, 255);
        v = (int'($urandom_range(0, 255)) * 100) / dx;
        if ($urandom_range(0, 1)) v = -v;
      end
      4: v = int'($urandom);
      default: v = $urandom_range(0, 1) ? 99000 : -99000;
    endcase
    return int'($signed(SLOPE_W'(v)));
  endfunction

  initial begin
    int cx, cy, rad, rl, rh, ll, lh, en, tmp, ox, oy, tries;

    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed: reset setup, sector disabled
    send_offset(0, 0);
    send_offset(255, 255);

    // Directed: corner centre, full radius, window edges on exact slopes
    drain_pipe();
    set_sector(1023, 0, 255, 100, 200, -99000, -50, 1);
    send_offset(0, 0);
    send_offset(10, 10);
    send_offset(10, 20);
    send_offset(0, 255);
    send_offset(255, 0);
    send_offset(180, 180);
    send_offset(181, 181);
    send_offset(1, 254);
    send_offset(7, 3);
    send_offset(3, 7);
    send_offset(255, 255);
    send_offset(0, 1);

    // Directed: zero radius, sentinel and out-of-range bounds
    drain_pipe();
    set_sector(0, 1023, 0, -100000, 100000, -131072, 131071, 1);
    send_offset(0, 0);
    send_offset(1, 0);
    send_offset(0, 1);

    // Directed: enable cleared with every window wide open
    drain_pipe();
    set_sector(512, 512, 255, -100000, 100000, -100000, 100000, 0);
    send_offset(5, 5);
    send_offset(0, 0);

    // Random sector settings with mostly in-disc offsets
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES / 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 25;
      end else if (p == 2 * RANDOM_PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain_pipe();
      cx = (p == 0) ? 0 : (p == 1) ? 1023 : int'($urandom_range(0, 1023));
      cy = (p == 0) ? 1023 : (p == 1) ? 0 : int'($urandom_range(0, 1023));
      if ($urandom_range(0, 3) == 0) cx = int'($urandom);
      if ($urandom_range(0, 3) == 0) cy = int'($urandom);
      case (p % 4)
        0:       rad = 255;
        1:       rad = $urandom_range(0, 8);
        default: rad = $urandom_range(0, 255);
      endcase
      if ($urandom_range(0, 3) == 0) rad = (int'($urandom) & ~255) | rad;
      rl = pick_bound();
      rh = pick_bound();
      ll = pick_bound();
      lh = pick_bound();
      if (rl > rh && $urandom_range(0, 3) != 0) begin
        tmp = rl; rl = rh; rh = tmp;
      end
      if (ll > lh && $urandom_range(0, 3) != 0) begin
        tmp = ll; ll = lh; lh = tmp;
      end
      en = (int'($urandom) & ~1) | int'($urandom_range(0, 9) != 0);
      set_sector(cx, cy, rad, rl, rh, ll, lh, en);

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 9) < 7) begin
          tries = 0;
          do begin
            ox = $urandom_range(0, radius_now);
            oy = $urandom_range(0, radius_now);
            tries++;
          end while (ox * ox + oy * oy > radius_now * radius_now && tries < 8);
        end else begin
          ox = $urandom_range(0, 255);
          oy = $urandom_range(0, 255);
        end
        send_offset(ox, oy);
        // occasionally let the pipe run dry mid-setting
        if ($urandom_range(0, 199) == 0) drain_pipe();
      end
    end

    drain_pipe();
    $display("Sent %0d grid offsets over %0d sector setups, %0d result beats compared,",
             offsets_sent, settings_run, beats_checked);
    $display("with sender and receiver stalls swapped and then removed.");
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
